### rtl/core/bfla_pkg.sv
// ----------------------------------------------------------------------------
// bfla_pkg
// Shared types and constants for the block free list allocator.
// ----------------------------------------------------------------------------
package bfla_pkg;

  localparam int unsigned BLOCK_W        = 16;
  localparam int unsigned COUNT_W        = 17;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned MIN_BLOCKS     = 1024;
  localparam int unsigned MAX_BLOCKS_DEF = 65536;
  localparam int unsigned BLOCK_SPACE    = 65536;  // block numbers are 16 bits

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(65536);

  // item opcodes
  localparam logic [OP_W-1:0] OP_POPULATE = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK     = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC    = 2'd2;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd3;

  // work classes decided by the front end
  typedef enum logic [2:0] {
    KIND_POPULATE,
    KIND_MARK,
    KIND_ALLOC,
    KIND_FREE,
    KIND_REJECT,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [BLOCK_W-1:0]   block;
    logic [COUNT_W-1:0]   cnt;    // effective block count at accept time
  } entry_t;

  // front -> back: queue head
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  // back -> front: control
  typedef struct packed {
    logic pop;
    logic clearing;
  } bctl_t;

endpackage

### rtl/core/bfla_ram.sv
// ----------------------------------------------------------------------------
// bfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfla_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bfla_front.sv
// ----------------------------------------------------------------------------
// bfla_front
// Accepts items, range-checks and classifies them, and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module bfla_front
  import bfla_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [BLOCK_W-1:0]  block_i,
  input  logic [COUNT_W-1:0]  block_count_i,
  input  bctl_t               bctl_i,
  output qhead_t              qhead_o
);

  localparam logic [COUNT_W-1:0] CAP  = COUNT_W'(DEPTH);
  localparam logic [COUNT_W-1:0] LOW  = COUNT_W'(MIN_BLOCKS);

  logic [COUNT_W-1:0] eff_cnt;
  logic               out_of_range;
  logic               accept;
  entry_t             new_entry;

  entry_t     q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  // effective count, saturated to the supported range
  always_comb begin
    if (block_count_i < LOW) begin
      eff_cnt = LOW;
    end else if (block_count_i > CAP) begin
      eff_cnt = CAP;
    end else begin
      eff_cnt = block_count_i;
    end
  end

  assign out_of_range = {1'b0, block_i} >= eff_cnt;

  always_comb begin
    new_entry.block = block_i;
    new_entry.cnt   = eff_cnt;
    unique case (op_i)
      OP_POPULATE: new_entry.kind = KIND_POPULATE;
      OP_MARK: begin
        if (out_of_range) begin
          new_entry.kind = KIND_REJECT;
        end else if (block_i == '0) begin
          new_entry.kind = KIND_NOP;
        end else begin
          new_entry.kind = KIND_MARK;
        end
      end
      OP_ALLOC: new_entry.kind = KIND_ALLOC;
      OP_FREE: begin
        if (out_of_range || block_i == '0) begin
          new_entry.kind = KIND_REJECT;
        end else begin
          new_entry.kind = KIND_FREE;
        end
      end
      default: new_entry.kind = KIND_REJECT;
    endcase
  end

  assign busy_o = (fill_q == 2'd2) || bctl_i.clearing;
  assign accept = start_i && !busy_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (accept) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (bctl_i.pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({accept, bctl_i.pop})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem_q[wr_ptr_q] <= new_entry;
    end
  end

  assign qhead_o.valid = fill_q != 2'd0;
  assign qhead_o.entry = q_mem_q[rd_ptr_q];

endmodule

### rtl/core/bfla_back.sv
// ----------------------------------------------------------------------------
// bfla_back
// Executes queued items on the linked free list: link RAM read, then the
// list update, plus the populate sweep and the post-reset clearing sweep.
// ----------------------------------------------------------------------------
module bfla_back
  import bfla_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_BLOCKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qhead_t               qhead_i,
  output bctl_t                bctl_o,
  output logic                 done_o,
  output logic [BLOCK_W-1:0]   granted_block_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [BLOCK_W-1:0]   free_left_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_e;

  state_e              state_q;
  kind_e               kind_q;
  logic [AW-1:0]       blk_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [AW-1:0]       sweep_q;
  logic [AW-1:0]       head_q;
  logic [AW-1:0]       tail_q;
  logic [BLOCK_W-1:0]  count_q;
  logic                done_q;
  logic [BLOCK_W-1:0]  granted_q;
  logic [STATUS_W-1:0] status_q;

  // RAM ports
  logic [AW-1:0] raddr;
  logic          nx_we, pv_we, ls_we;
  logic [AW-1:0] nx_waddr, pv_waddr, ls_waddr;
  logic [AW-1:0] nx_wdata, pv_wdata;
  logic          ls_wdata;
  logic [AW-1:0] nx_rdata, pv_rdata;
  logic          ls_rdata;

  entry_t        ent;
  logic [AW-1:0] nb, pb;
  logic          do_unlink, do_push;
  logic [COUNT_W-1:0] sweep_ext, sweep_inc;

  assign ent = qhead_i.entry;

  assign bctl_o.pop      = (state_q == ST_IDLE) && qhead_i.valid;
  assign bctl_o.clearing = (state_q == ST_CLEAR);

  // neighbors of the block under work; the head's prev link is read as null
  assign nb = nx_rdata;
  assign pb = (blk_q == head_q) ? '0 : pv_rdata;

  assign do_unlink = (state_q == ST_READ) &&
                     ((kind_q == KIND_ALLOC) || (kind_q == KIND_MARK && ls_rdata));
  assign do_push   = (state_q == ST_READ) && (kind_q == KIND_FREE) && !ls_rdata;

  assign sweep_ext = COUNT_W'(sweep_q);
  assign sweep_inc = sweep_ext + COUNT_W'(1);

  assign raddr = (ent.kind == KIND_ALLOC) ? head_q : ent.block[AW-1:0];

  always_comb begin
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    ls_we    = 1'b0;
    nx_waddr = blk_q;
    pv_waddr = blk_q;
    ls_waddr = blk_q;
    nx_wdata = '0;
    pv_wdata = '0;
    ls_wdata = 1'b0;
    if (state_q == ST_CLEAR || state_q == ST_FILL) begin
      nx_waddr = sweep_q;
      pv_waddr = sweep_q;
      ls_waddr = sweep_q;
      nx_we    = (state_q == ST_FILL);
      pv_we    = (state_q == ST_FILL);
      ls_we    = 1'b1;
      nx_wdata = (sweep_inc < cnt_q) ? sweep_inc[AW-1:0] : '0;
      pv_wdata = sweep_q - AW'(1);
      ls_wdata = (state_q == ST_FILL) && (sweep_q != '0) && (sweep_ext < cnt_q);
    end else if (do_unlink) begin
      nx_we    = (blk_q != head_q);
      nx_waddr = pb;
      nx_wdata = nb;
      pv_we    = (blk_q != tail_q);
      pv_waddr = nb;
      pv_wdata = pb;
      ls_we    = 1'b1;
      ls_wdata = 1'b0;
    end else if (do_push) begin
      nx_we    = 1'b1;
      nx_waddr = blk_q;
      nx_wdata = (count_q == '0) ? '0 : head_q;
      pv_we    = (count_q != '0);
      pv_waddr = head_q;
      pv_wdata = blk_q;
      ls_we    = 1'b1;
      ls_wdata = 1'b1;
    end
  end

  bfla_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (raddr),
    .rdata_o (nx_rdata)
  );

  bfla_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .raddr_i (raddr),
    .rdata_o (pv_rdata)
  );

  bfla_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_listed_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .raddr_i (raddr),
    .rdata_o (ls_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      kind_q    <= KIND_NOP;
      blk_q     <= '0;
      cnt_q     <= '0;
      sweep_q   <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      granted_q <= '0;
      status_q  <= STATUS_OK;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          done_q <= 1'b0;
          if (sweep_q == LAST) begin
            sweep_q <= '0;
            state_q <= ST_IDLE;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (qhead_i.valid) begin
            kind_q    <= ent.kind;
            blk_q     <= raddr;
            cnt_q     <= ent.cnt;
            granted_q <= '0;
            unique case (ent.kind)
              KIND_REJECT: begin
                done_q   <= 1'b1;
                status_q <= STATUS_RANGE;
              end
              KIND_NOP: begin
                done_q   <= 1'b1;
                status_q <= STATUS_OK;
              end
              KIND_ALLOC: begin
                if (count_q == '0) begin
                  done_q   <= 1'b1;
                  status_q <= STATUS_NO_SPACE;
                end else begin
                  done_q   <= 1'b0;
                  status_q <= STATUS_OK;
                  state_q  <= ST_READ;
                end
              end
              KIND_POPULATE: begin
                done_q   <= 1'b0;
                status_q <= STATUS_OK;
                sweep_q  <= '0;
                state_q  <= ST_FILL;
              end
              default: begin
                done_q   <= 1'b0;
                status_q <= STATUS_OK;
                state_q  <= ST_READ;
              end
            endcase
          end else begin
            done_q <= 1'b0;
          end
        end
        ST_READ: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
          if (kind_q == KIND_ALLOC) begin
            granted_q <= BLOCK_W'(blk_q);
          end
          if (do_unlink) begin
            count_q <= count_q - BLOCK_W'(1);
            if (count_q == BLOCK_W'(1)) begin
              head_q <= '0;
              tail_q <= '0;
            end else begin
              if (blk_q == head_q) begin
                head_q <= nb;
              end
              if (blk_q == tail_q) begin
                tail_q <= pb;
              end
            end
          end else if (do_push) begin
            count_q <= count_q + BLOCK_W'(1);
            head_q  <= blk_q;
            if (count_q == '0) begin
              tail_q <= blk_q;
            end
          end else if (kind_q == KIND_FREE) begin
            status_q <= STATUS_MISMATCH;
          end
        end
        ST_FILL: begin
          if (sweep_q == LAST) begin
            sweep_q <= '0;
            head_q  <= AW'(1);
            tail_q  <= AW'(cnt_q - COUNT_W'(1));
            count_q <= BLOCK_W'(cnt_q - COUNT_W'(1));
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            sweep_q <= sweep_q + AW'(1);
            done_q  <= 1'b0;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign granted_block_o = granted_q;
  assign status_o        = status_q;
  assign free_left_o     = count_q;

endmodule

### rtl/core/block_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// block_free_list_allocator_core
// Block allocator over a doubly linked free list kept in on-chip RAM.
// ----------------------------------------------------------------------------
// Items are taken when start_i is high and busy_o is low; each item yields
// exactly one result, shown for one cycle with done_o high, and the receiver
// cannot hold it off. Accepted items wait in a two-entry queue; busy_o rises
// when that queue is full. Per item, once at the queue head: rejected items,
// mark of block 0 and allocate on an empty list are answered straight from
// idle; allocate, mark and free read the link RAMs, then write back; populate
// sweeps every RAM row, DEPTH = min(MAX_BLOCKS, 65536). After reset a
// clearing pass zeroes the listed flags; busy_o stays high throughout,
// while block_count writes are taken as usual. block_count is sampled at
// accept time and saturated to 1024..DEPTH; change it only when idle.
// ----------------------------------------------------------------------------
module block_free_list_allocator_core
  import bfla_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [BLOCK_W-1:0]   block_i,
  // configuration
  input  logic                 block_count_we_i,
  input  logic [COUNT_W-1:0]   block_count_i,
  // result channel
  output logic                 done_o,
  output logic [BLOCK_W-1:0]   granted_block_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [BLOCK_W-1:0]   free_left_o
);

  // block numbers are 16 bits, so no more than 64K rows are ever addressed
  localparam int unsigned DEPTH = (MAX_BLOCKS > BLOCK_SPACE) ? BLOCK_SPACE : MAX_BLOCKS;

  logic [COUNT_W-1:0] block_count_q;
  qhead_t             qhead;
  bctl_t              bctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= COUNT_RESET;
    end else if (block_count_we_i) begin
      block_count_q <= block_count_i;
    end
  end

  // front: accept, range check, classify, queue
  bfla_front #(.DEPTH(DEPTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .block_i       (block_i),
    .block_count_i (block_count_q),
    .bctl_i        (bctl),
    .qhead_o       (qhead)
  );

  // back: list updates on the link RAMs
  bfla_back #(.DEPTH(DEPTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .qhead_i         (qhead),
    .bctl_o          (bctl),
    .done_o          (done_o),
    .granted_block_o (granted_block_o),
    .status_o        (status_o),
    .free_left_o     (free_left_o)
  );

`ifndef ASSERT_OFF
  // only a successful allocate hands out a block
  a_err_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STATUS_OK |-> granted_block_o == '0)
    else $error("granted block on a failed item");

  // no-space is reported only when the list is empty
  a_nospace_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STATUS_NO_SPACE |-> free_left_o == '0)
    else $error("no-space with blocks left");

  // after a grant the count cannot be at its ceiling
  a_grant_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && granted_block_o != '0 |-> free_left_o != '1)
    else $error("free count too high after grant");
`endif

endmodule

### tb/block_free_list_allocator_core_checker.sv
// ----------------------------------------------------------------------------
// block_free_list_allocator_core_checker
// Watches the command, result and block_count ports, predicts every result
// and compares it field by field.
// ----------------------------------------------------------------------------
module block_free_list_allocator_core_checker
  import bfla_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [OP_W-1:0]     op_i,
  input  logic [BLOCK_W-1:0]  block_i,
  input  logic                cfg_we_i,
  input  logic [COUNT_W-1:0]  cfg_data_i,
  input  logic                done_i,
  input  logic [BLOCK_W-1:0]  granted_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [BLOCK_W-1:0]  left_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int unsigned PRINT_CAP = 60;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [BLOCK_W-1:0]  granted;
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  left;
  } reply_t;

  reply_t reply_q[$];

  // shadow of the allocator
  bit [BLOCK_W-1:0]   link_next [BLOCK_SPACE];
  bit [BLOCK_W-1:0]   link_prev [BLOCK_SPACE];
  bit                 on_list   [BLOCK_SPACE];
  bit [BLOCK_W-1:0]   list_head;
  bit [BLOCK_W-1:0]   list_tail;
  bit [BLOCK_W-1:0]   list_len;
  bit [COUNT_W-1:0]   count_reg;

  int errors;
  int checked;

  assign errors_o  = errors;
  assign pending_o = reply_q.size();
  assign checked_o = checked;

  task automatic report(input string msg);
    if (errors < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  // block_count saturated to 1024..min(MAX_BLOCKS, 65536)
  function automatic int unsigned usable_count();
    int unsigned cap;
    int unsigned c;
    cap = (MAX_BLOCKS > BLOCK_SPACE) ? BLOCK_SPACE : MAX_BLOCKS;
    c   = count_reg;
    if (c < MIN_BLOCKS) c = MIN_BLOCKS;
    if (c > cap) c = cap;
    return c;
  endfunction

  function automatic void unlink_block(input bit [BLOCK_W-1:0] b);
    bit [BLOCK_W-1:0] p;
    bit [BLOCK_W-1:0] n;
    p = link_prev[b];
    n = link_next[b];
    if (b == list_head) list_head = n; else link_next[p] = n;
    if (b == list_tail) list_tail = p; else link_prev[n] = p;
    on_list[b] = 1'b0;
    list_len   = list_len - 1'b1;
    if (list_len == 0) begin
      list_head = '0;
      list_tail = '0;
    end
  endfunction

  function automatic void push_head(input bit [BLOCK_W-1:0] b);
    if (list_len == 0) begin
      link_next[b] = '0;
      list_tail    = b;
    end else begin
      link_next[b]         = list_head;
      link_prev[list_head] = b;
    end
    link_prev[b] = '0;
    list_head    = b;
    on_list[b]   = 1'b1;
    list_len     = list_len + 1'b1;
  endfunction

  function automatic reply_t serve(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk);
    int unsigned lim;
    reply_t      r;
    lim       = usable_count();
    r.op      = op;
    r.granted = '0;
    r.status  = STATUS_OK;
    case (op)
      OP_POPULATE: begin
        for (int i = 0; i < BLOCK_SPACE; i++) on_list[i] = 1'b0;
        for (int unsigned i = 1; i < lim; i++) begin
          link_next[i] = (i + 1 < lim) ? BLOCK_W'(i + 1) : '0;
          link_prev[i] = BLOCK_W'(i - 1);
          on_list[i]   = 1'b1;
        end
        list_head = 1;
        list_tail = BLOCK_W'(lim - 1);
        list_len  = BLOCK_W'(lim - 1);
      end
      OP_MARK: begin
        if (blk >= lim) r.status = STATUS_RANGE;
        else if (blk != 0 && on_list[blk]) unlink_block(blk);
      end
      OP_ALLOC: begin
        if (list_len == 0) begin
          r.status = STATUS_NO_SPACE;
        end else begin
          r.granted = list_head;
          unlink_block(list_head);
        end
      end
      default: begin
        if (blk == 0 || blk >= lim) r.status = STATUS_RANGE;
        else if (on_list[blk]) r.status = STATUS_MISMATCH;
        else push_head(blk);
      end
    endcase
    r.left = list_len;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < BLOCK_SPACE; i++) on_list[i] = 1'b0;
      list_head = '0;
      list_tail = '0;
      list_len  = '0;
      count_reg = COUNT_RESET;
      reply_q.delete();
    end else begin
      if (done_i) begin
        if (reply_q.size() == 0) begin
          report("result seen with no item outstanding");
        end else begin
          want = reply_q.pop_front();
          checked++;
          if (granted_i !== want.granted)
            report($sformatf("op %0d granted_block got %0d want %0d",
                             want.op, granted_i, want.granted));
          if (status_i !== want.status)
            report($sformatf("op %0d status got %0d want %0d",
                             want.op, status_i, want.status));
          if (left_i !== want.left)
            report($sformatf("op %0d free_left got %0d want %0d",
                             want.op, left_i, want.left));
        end
      end
      if (start_i && !busy_i) reply_q.push_back(serve(op_i, block_i));
      if (cfg_we_i) count_reg = cfg_data_i;
    end
  end

endmodule

### tb/block_free_list_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// block_free_list_allocator_core_tb
// Drives directed and random allocator items through several block_count
// settings; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module block_free_list_allocator_core_tb;
  import bfla_pkg::*;

  localparam int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF;
  // the limit covers the slowest run: four populate sweeps, the clearing
  // pass after reset and every item behind a long gap
  localparam int unsigned RUN_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_WAIT = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [OP_W-1:0]     op_i;
  logic [BLOCK_W-1:0]  block_i;
  logic                block_count_we_i;
  logic [COUNT_W-1:0]  block_count_i;
  logic                done_o;
  logic [BLOCK_W-1:0]  granted_block_o;
  logic [STATUS_W-1:0] status_o;
  logic [BLOCK_W-1:0]  free_left_o;

  int errors;
  int pending;
  int checked;
  int cycles = 0;
  int issued [4];
  int settings;

  // saturated count, only used to aim block numbers near the range limit
  int unsigned count_now;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  block_free_list_allocator_core #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .block_i          (block_i),
    .block_count_we_i (block_count_we_i),
    .block_count_i    (block_count_i),
    .done_o           (done_o),
    .granted_block_o  (granted_block_o),
    .status_o         (status_o),
    .free_left_o      (free_left_o)
  );

  block_free_list_allocator_core_checker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_i     (busy_o),
    .op_i       (op_i),
    .block_i    (block_i),
    .cfg_we_i   (block_count_we_i),
    .cfg_data_i (block_count_i),
    .done_i     (done_o),
    .granted_i  (granted_block_o),
    .status_i   (status_o),
    .left_i     (free_left_o),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // watchdog: a hung handshake or a missing result ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("block_free_list_allocator_core test failed");
      $finish;
    end
  end

  // present one item at the falling edge, hold it until the block takes it;
  // start_i is left high afterwards, until pause or write_count drops it
  task automatic send(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk);
    @(negedge clk_i);
    start_i <= 1'b1;
    op_i    <= op;
    block_i <= blk;
    do @(posedge clk_i); while (busy_o);
    issued[op]++;
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // block_count only changes while nothing is in flight; every item has a
  // result, so an empty scoreboard means the block is idle
  task automatic write_count(input logic [COUNT_W-1:0] v);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    block_count_we_i <= 1'b1;
    block_count_i    <= v;
    @(negedge clk_i);
    block_count_we_i <= 1'b0;
    count_now = (v < MIN_BLOCKS) ? MIN_BLOCKS : (v > BLOCK_SPACE) ? BLOCK_SPACE : v;
    if (count_now > MAX_BLOCKS) count_now = MAX_BLOCKS;
    settings++;
  endtask

  // mostly no gap, often a short gap, now and then a long hole
  function automatic int gap_len(input bit gappy);
    int unsigned r;
    if (!gappy) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 12);
  endfunction

  // small block numbers collide with what populate and alloc hand out, the
  // top of the range hits the limit check, the rest is spread over 16 bits
  function automatic logic [BLOCK_W-1:0] pick_block(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return BLOCK_W'($urandom_range(24, 1));
    if (r < 70) return BLOCK_W'(lim - $urandom_range(8, 1));
    if (r < 80) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return BLOCK_W'(lim);
        2:       return '1;
        default: return BLOCK_W'(lim - 1);
      endcase
    end
    return BLOCK_W'($urandom);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return OP_FREE;
    if (r < 65) return OP_ALLOC;
    return OP_MARK;
  endfunction

  // one random stretch, optionally behind a block_count write and a
  // populate; populate sweeps the whole RAM, so it is kept out of the mix
  task automatic run_phase(input bit do_write, input logic [COUNT_W-1:0] v,
                           input bit do_pop, input int n, input bit gappy);
    if (do_write) write_count(v);
    if (do_pop) send(OP_POPULATE, BLOCK_W'($urandom));
    repeat (n) begin
      send(pick_op(), pick_block(count_now));
      pause(gap_len(gappy));
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    op_i             = OP_POPULATE;
    block_i          = '0;
    block_count_we_i = 1'b0;
    block_count_i    = '0;
    count_now        = (MAX_BLOCKS > BLOCK_SPACE) ? BLOCK_SPACE : MAX_BLOCKS;
    settings         = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed, list empty after reset, block_count at its reset value
    send(OP_ALLOC, BLOCK_W'($urandom));  // empty list: no space
    send(OP_MARK, '0);                   // block 0: no-op
    send(OP_FREE, '0);                   // block 0 is never valid
    send(OP_MARK, BLOCK_W'(7));          // unlisted: nothing changes
    send(OP_FREE, BLOCK_W'(1));          // first link into empty list
    send(OP_FREE, BLOCK_W'(1));          // already listed: state mismatch
    send(OP_FREE, '1);                   // top block number
    send(OP_FREE, BLOCK_W'(2000));
    send(OP_MARK, '1);                   // unlink from the middle
    send(OP_ALLOC, BLOCK_W'($urandom));  // takes head, 2000
    send(OP_FREE, BLOCK_W'(2000));

    // low setting below the floor, saturates to 1024
    write_count('0);
    send(OP_MARK, BLOCK_W'(2000));       // listed but now out of range
    send(OP_FREE, BLOCK_W'(1024));       // first out-of-range number
    send(OP_ALLOC, BLOCK_W'($urandom));  // stale out-of-range block still granted
    send(OP_ALLOC, BLOCK_W'($urandom));
    send(OP_ALLOC, BLOCK_W'($urandom));  // drained: no space again
    send(OP_FREE, BLOCK_W'(1023));       // last valid block

    // lean list, no populate: empty-list cases come up often here
    run_phase(1'b0, '0, 1'b0, 250, 1'b1);

    // --- directed around populate
    send(OP_POPULATE, BLOCK_W'($urandom));
    send(OP_MARK, BLOCK_W'(1023));       // tail
    send(OP_MARK, BLOCK_W'(1));          // head
    send(OP_MARK, BLOCK_W'(512));        // middle
    send(OP_ALLOC, BLOCK_W'($urandom));
    send(OP_FREE, BLOCK_W'(1));
    send(OP_FREE, BLOCK_W'(3));          // still listed
    send(OP_MARK, BLOCK_W'(1023));       // already taken out

    // --- random phases over several block_count settings
    run_phase(1'b1, COUNT_W'(65536), 1'b0, 150, 1'b0);
    run_phase(1'b1, '1, 1'b1, 175, 1'b1);   // saturates high, 65535 listed
    run_phase(1'b1, COUNT_W'($urandom_range(65535, 1025)), 1'b0, 150, 1'b1);
    run_phase(1'b1, COUNT_W'(MIN_BLOCKS), 1'b0, 150, 1'b1);
    run_phase(1'b1, COUNT_W'($urandom), 1'b1, 125, 1'b1);
    run_phase(1'b1, COUNT_W'(MIN_BLOCKS + $urandom_range(64)), 1'b1, 100, 1'b0);

    // drain: every result in, then a short settle
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("covered %0d populate, %0d mark, %0d alloc and %0d free items",
             issued[OP_POPULATE], issued[OP_MARK], issued[OP_ALLOC], issued[OP_FREE]);
    $display("%0d results compared over %0d block_count settings, %0d mismatches",
             checked, settings, errors);
    if (errors == 0) begin
      $display("block_free_list_allocator_core test passed");
    end else begin
      $display("block_free_list_allocator_core test failed");
    end
    $finish;
  end

endmodule
